[hdl/lmt_pkg.sv]
// ---------------------------------------------------------------------------
// lmt_pkg
// Shared types and constants of the longest-match tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package lmt_pkg;

   localparam int DEF_RULES  = 8;
   localparam int DEF_STATES = 32;
   localparam int DEF_EDGES  = 4;
   localparam int DEF_WINDOW = 64;

   localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [15:0] POS_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_LOAD_EDGE  = 2'd0,
      OP_SET_ACCEPT = 2'd1,
      OP_FEED_BYTE  = 2'd2,
      OP_END_INPUT  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_LITERAL = 3'd0,
      KIND_LETTER  = 3'd1,
      KIND_DIGIT   = 3'd2,
      KIND_SPACE   = 3'd3,
      KIND_ANY     = 3'd4
   } edge_kind_type;

   // register index, paddr[2]
   localparam logic [0:0] REG_RULES_IN_USE = 1'b0;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] char_code;
      logic [4:0] target;
   } edge_entry_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] target;
   } edge_result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP_RULE,
      ST_STEP_RD,
      ST_STEP_CHK,
      ST_STEP_ACC,
      ST_SETTLE,
      ST_BEST,
      ST_POS_RD,
      ST_POS_UPD,
      ST_ADVANCE,
      ST_REPLAY_RD,
      ST_REPLAY_BYTE
   } state_type;

endpackage

`default_nettype wire

[hdl/longest_match_multi_rule_tokenizer_top.sv]
// ---------------------------------------------------------------------------
// longest_match_multi_rule_tokenizer_top
// Longest-match tokenizer over loaded per-rule automata.
// ---------------------------------------------------------------------------
// Usage: req_ beats carry an operation in tuser: load an edge, set an
// accepting mark, feed one text byte, or end of input. Load beats leave the
// sequencer idle. A feed beat writes the byte into the window if it has room,
// then a sequencer walks every live rule and its edge slots one at a time
// through the shared edge compare: a rule step, a read and a check per slot,
// and a step for the accepting mark of the target taken. Each token emitted
// adds the longest-match pick over the rules, a line/column walk over the
// token bytes, and a replay of the pending bytes through fresh rules, each
// byte read from the window and put through the same rule walk as a feed.
// req_tready is high only while the sequencer is idle.
// rsp_ beats carry one token each; rsp_tlast marks the last token caused by
// a request beat. One output register sits on rsp_; when the receiver stalls
// the sequencer waits before pushing the next token.
// csr_ is an APB port holding rules_in_use at address 0; write it only while
// idle. Reset (synchronous) clears the accepting marks, window, rule state and
// position (line 1, column 0); the edge table is unknown until loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module longest_match_multi_rule_tokenizer_top import lmt_pkg::*; #(
   parameter int RULES  = DEF_RULES,
   parameter int STATES = DEF_STATES,
   parameter int EDGES  = DEF_EDGES,
   parameter int WINDOW = DEF_WINDOW
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] rule_index, [7:3] state_index, [9:8] edge_slot, [12:10] edge_kind,
   // [20:13] edge_char, [25:21] next_state, [26] accept_flag, [34:27] byte_value
   input  wire logic [39:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] tok_id, [10:4] token_length, [26:11] token_line, [42:27] token_column
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int RW  = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int RCW = $clog2(RULES + 1);
   localparam int SW  = $clog2(STATES);
   localparam int ECW = $clog2(EDGES + 1);
   localparam int DEPTH = RULES * STATES * EDGES;
   localparam int AW  = $clog2(DEPTH);
   localparam int ACW = $clog2(RULES * STATES);
   localparam int PW  = $clog2(WINDOW);
   localparam int FW  = $clog2(WINDOW + 1);

   // request fields
   op_type     req_op;
   logic [2:0] req_rule;
   logic [4:0] req_state;
   logic [1:0] req_slot;
   logic [2:0] req_kind;
   logic [7:0] req_char;
   logic [4:0] req_next;
   logic       req_flag;
   logic [7:0] req_byte;
   logic       req_fire;

   assign req_op    = op_type'(req_tuser);
   assign req_rule  = req_tdata[2:0];
   assign req_state = req_tdata[7:3];
   assign req_slot  = req_tdata[9:8];
   assign req_kind  = req_tdata[12:10];
   assign req_char  = req_tdata[20:13];
   assign req_next  = req_tdata[25:21];
   assign req_flag  = req_tdata[26];
   assign req_byte  = req_tdata[34:27];

   // registers
   state_type         state_ff, state_in;
   logic [3:0]        rules_in_use_ff;
   logic [RCW-1:0]    rule_ff, rule_in;
   logic [ECW-1:0]    slot_ff, slot_in;
   logic [7:0]        cur_byte_ff, cur_byte_in;
   logic [FW-1:0]     count_ff, count_in;
   logic [FW-1:0]     idx_ff, idx_in;
   logic              final_ff, final_in;
   logic              replay_ff, replay_in;
   logic [PW-1:0]     head_ff, head_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [15:0]       line_ff, line_in;
   logic [15:0]       col_ff, col_in;
   logic [SW-1:0]     rstate_ff [RULES];
   logic [SW-1:0]     rstate_in [RULES];
   logic [RULES-1:0]  alive_ff, alive_in;
   logic [FW-1:0]     blen_ff [RULES];
   logic [FW-1:0]     blen_in [RULES];
   logic [RULES*STATES-1:0] accept_ff, accept_in;
   logic              acc_bit_ff;
   logic [FW-1:0]     best_ff, best_in;
   logic [3:0]        bid_ff, bid_in;
   logic [3:0]        pid_ff, pid_in;
   logic [FW-1:0]     plen_ff, plen_in;
   logic [15:0]       pline_ff, pline_in;
   logic [15:0]       pcol_ff, pcol_in;
   logic              have_pend_ff, have_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;

   // helpers
   logic [RCW-1:0]    n_act;
   logic              any_alive;
   logic              rule_done;
   logic [RW-1:0]     rsel;
   logic              cond;
   logic              can_push;
   logic              load_ok;
   logic              mark_ok;
   logic [FW:0]       wsum;
   logic [PW-1:0]     wr_pos;
   logic [FW:0]       rsum;
   logic [PW-1:0]     rd_pos;
   logic [FW:0]       hsum;
   logic [PW-1:0]     head_adv;
   logic [FW-1:0]     fin_len;
   logic [7:0]        win_rdata;
   edge_result_type   eres;
   logic [AW-1:0]     edge_rd_addr;
   logic [AW-1:0]     edge_wr_addr;
   logic [ACW-1:0]    acc_rd_addr;
   logic [ACW-1:0]    acc_wr_addr;
   logic              tgt_bad;
   logic              last_slot;
   edge_entry_type    edge_wr_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (int'(rules_in_use_ff) > RULES) begin
         n_act = RCW'(RULES);
      end else begin
         n_act = RCW'(rules_in_use_ff);
      end
   end

   always_comb begin
      any_alive = 1'b0;
      for (int r = 0; r < RULES; r++) begin
         if (r < int'(n_act) && alive_ff[r]) begin
            any_alive = 1'b1;
         end
      end
   end

   assign rule_done = (rule_ff >= n_act);
   assign rsel      = rule_ff[RW-1:0];
   assign cond      = (fill_ff != '0) &&
                      (final_ff || !any_alive || int'(fill_ff) >= WINDOW);
   assign can_push  = !rsp_valid_ff || rsp_tready;

   assign load_ok = (int'(req_rule) < RULES) && (int'(req_state) < STATES) &&
                    (int'(req_slot) < EDGES);
   assign mark_ok = (int'(req_rule) < RULES) && (int'(req_state) < STATES);

   // window positions, wrapped
   always_comb begin
      wsum = (FW+1)'(head_ff) + (FW+1)'(fill_ff);
      if (int'(wsum) >= WINDOW) wsum = wsum - (FW+1)'(WINDOW);
      wr_pos = wsum[PW-1:0];
      rsum = (FW+1)'(head_ff) + (FW+1)'(idx_ff);
      if (int'(rsum) >= WINDOW) rsum = rsum - (FW+1)'(WINDOW);
      rd_pos = rsum[PW-1:0];
      hsum = (FW+1)'(head_ff) + (FW+1)'(plen_ff);
      if (int'(hsum) >= WINDOW) hsum = hsum - (FW+1)'(WINDOW);
      head_adv = hsum[PW-1:0];
   end

   always_comb begin
      fin_len = (best_ff == '0) ? FW'(1) : best_ff;
      if (fin_len > fill_ff) fin_len = fill_ff;
   end

   assign edge_wr_addr = AW'((int'(req_rule) * STATES + int'(req_state)) * EDGES +
                             int'(req_slot));
   assign edge_rd_addr = AW'((int'(rsel) * STATES + int'(rstate_ff[rsel])) * EDGES +
                             int'(slot_ff));
   assign acc_wr_addr  = ACW'(int'(req_rule) * STATES + int'(req_state));
   assign acc_rd_addr  = ACW'(int'(rsel) * STATES + int'(eres.target));
   assign tgt_bad      = (int'(eres.target) >= STATES);
   assign last_slot    = (int'(slot_ff) + 1 >= EDGES);

   assign edge_wr_data.kind      = req_kind;
   assign edge_wr_data.char_code = req_char;
   assign edge_wr_data.target    = req_next;

   lmt_edge_unit #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_edge (
      .clock    (clock),
      .wr_en    (req_fire && req_op == OP_LOAD_EDGE && load_ok),
      .wr_addr  (edge_wr_addr),
      .wr_data  (edge_wr_data),
      .rd_addr  (edge_rd_addr),
      .cur_byte (cur_byte_ff),
      .result   (eres)
   );

   lmt_window_mem #(
      .WINDOW (WINDOW),
      .PW     (PW)
   ) u_window (
      .clock   (clock),
      .wr_en   (req_fire && req_op == OP_FEED_BYTE && int'(fill_ff) < WINDOW),
      .wr_addr (wr_pos),
      .wr_data (req_byte),
      .rd_addr (rd_pos),
      .rd_data (win_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_FEED_BYTE: begin
                     if (int'(fill_ff) < WINDOW && any_alive) state_in = ST_STEP_RULE;
                     else state_in = ST_SETTLE;
                  end
                  OP_END_INPUT: state_in = ST_SETTLE;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_STEP_RULE: begin
            if (rule_done) state_in = replay_ff ? ST_REPLAY_RD : ST_SETTLE;
            else if (alive_ff[rsel]) state_in = ST_STEP_RD;
         end
         ST_STEP_RD: state_in = ST_STEP_CHK;
         ST_STEP_CHK: begin
            if (eres.hit) state_in = tgt_bad ? ST_STEP_RULE : ST_STEP_ACC;
            else if (last_slot) state_in = ST_STEP_RULE;
            else state_in = ST_STEP_RD;
         end
         ST_STEP_ACC: state_in = ST_STEP_RULE;
         ST_SETTLE: begin
            if (!have_pend_ff || can_push) begin
               state_in = cond ? ST_BEST : ST_IDLE;
            end
         end
         ST_BEST:        if (rule_done) state_in = ST_POS_RD;
         ST_POS_RD:      state_in = (idx_ff >= plen_ff) ? ST_ADVANCE : ST_POS_UPD;
         ST_POS_UPD:     state_in = ST_POS_RD;
         ST_ADVANCE:     state_in = ST_REPLAY_RD;
         ST_REPLAY_RD: begin
            if (idx_ff >= fill_ff || !any_alive) state_in = ST_SETTLE;
            else state_in = ST_REPLAY_BYTE;
         end
         ST_REPLAY_BYTE: state_in = ST_STEP_RULE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      rule_in      = rule_ff;
      slot_in      = slot_ff;
      cur_byte_in  = cur_byte_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      final_in     = final_ff;
      replay_in    = replay_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      rstate_in    = rstate_ff;
      alive_in     = alive_ff;
      blen_in      = blen_ff;
      accept_in    = accept_ff;
      best_in      = best_ff;
      bid_in       = bid_ff;
      pid_in       = pid_ff;
      plen_in      = plen_ff;
      pline_in     = pline_ff;
      pcol_in      = pcol_ff;
      have_pend_in = have_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_SET_ACCEPT: begin
                     if (mark_ok) accept_in[acc_wr_addr] = req_flag;
                  end
                  OP_FEED_BYTE: begin
                     final_in = 1'b0;
                     if (int'(fill_ff) < WINDOW) begin
                        fill_in     = fill_ff + FW'(1);
                        count_in    = fill_ff + FW'(1);
                        cur_byte_in = req_byte;
                        rule_in     = '0;
                        replay_in   = 1'b0;
                     end
                  end
                  OP_END_INPUT: final_in = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_STEP_RULE: begin
            slot_in = '0;
            if (!rule_done && !alive_ff[rsel]) rule_in = rule_ff + RCW'(1);
            if (rule_done && replay_ff) idx_in = idx_ff + FW'(1);
         end
         ST_STEP_CHK: begin
            if (eres.hit) begin
               if (tgt_bad) begin
                  alive_in[rsel] = 1'b0;
                  rule_in = rule_ff + RCW'(1);
               end else begin
                  rstate_in[rsel] = SW'(eres.target);
               end
            end else if (last_slot) begin
               alive_in[rsel] = 1'b0;
               rule_in = rule_ff + RCW'(1);
            end else begin
               slot_in = slot_ff + ECW'(1);
            end
         end
         ST_STEP_ACC: begin
            // accepting mark of the target, read on the previous edge
            if (acc_bit_ff) blen_in[rsel] = count_ff;
            rule_in = rule_ff + RCW'(1);
         end
         ST_SETTLE: begin
            if (!have_pend_ff || can_push) begin
               if (have_pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = !cond;
                  rsp_data_in  = {5'd0, pcol_ff, pline_ff, 7'(plen_ff), pid_ff};
                  have_pend_in = 1'b0;
               end
               rule_in = '0;
               best_in = '0;
               bid_in  = '0;
               if (!cond && final_ff) begin
                  for (int r = 0; r < RULES; r++) begin
                     rstate_in[r] = '0;
                     blen_in[r]   = '0;
                  end
                  alive_in = '1;
               end
            end
         end
         ST_BEST: begin
            if (rule_done) begin
               pid_in       = (best_ff == '0) ? 4'd0 : bid_ff;
               plen_in      = fin_len;
               pline_in     = line_ff;
               pcol_in      = col_ff;
               have_pend_in = 1'b1;
               idx_in       = '0;
            end else begin
               if (blen_ff[rsel] > best_ff) begin
                  best_in = blen_ff[rsel];
                  bid_in  = 4'(int'(rule_ff) + 1);
               end
               rule_in = rule_ff + RCW'(1);
            end
         end
         ST_POS_UPD: begin
            if (col_ff != POS_MAX) col_in = col_ff + 16'd1;
            if (win_rdata == NEWLINE_CHAR) begin
               col_in = 16'd1;
               if (line_ff != POS_MAX) line_in = line_ff + 16'd1;
            end
            idx_in = idx_ff + FW'(1);
         end
         ST_ADVANCE: begin
            head_in = head_adv;
            fill_in = fill_ff - plen_ff;
            idx_in  = '0;
            for (int r = 0; r < RULES; r++) begin
               rstate_in[r] = '0;
               blen_in[r]   = '0;
            end
            alive_in = '1;
         end
         ST_REPLAY_BYTE: begin
            cur_byte_in = win_rdata;
            count_in    = idx_ff + FW'(1);
            rule_in     = '0;
            replay_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         line_ff      <= 16'd1;
         col_ff       <= '0;
         alive_ff     <= '1;
         accept_ff    <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         final_ff     <= 1'b0;
         replay_ff    <= 1'b0;
         rule_ff      <= '0;
         slot_ff      <= '0;
         idx_ff       <= '0;
         for (int r = 0; r < RULES; r++) begin
            rstate_ff[r] <= '0;
            blen_ff[r]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         alive_ff     <= alive_in;
         accept_ff    <= accept_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         final_ff     <= final_in;
         replay_ff    <= replay_in;
         rule_ff      <= rule_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         rstate_ff    <= rstate_in;
         blen_ff      <= blen_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
      count_ff    <= count_in;
      acc_bit_ff  <= accept_ff[acc_rd_addr];
      best_ff     <= best_in;
      bid_ff      <= bid_in;
      pid_ff      <= pid_in;
      plen_ff     <= plen_in;
      pline_ff    <= pline_in;
      pcol_ff     <= pcol_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         rules_in_use_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_RULES_IN_USE) begin
         rules_in_use_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_RULES_IN_USE) ? {28'd0, rules_in_use_ff} :
                                                            32'd0;

endmodule

`default_nettype wire

[hdl/lmt_edge_unit.sv]
// ---------------------------------------------------------------------------
// lmt_edge_unit
// Edge table memory with a registered read, and the byte class compare
// applied to the slot just read.
// ---------------------------------------------------------------------------
`default_nettype none

module lmt_edge_unit import lmt_pkg::*; #(
   parameter int DEPTH = DEF_RULES * DEF_STATES * DEF_EDGES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [AW-1:0]  wr_addr,
   input  wire edge_entry_type wr_data,
   input  wire logic [AW-1:0]  rd_addr,
   input  wire logic [7:0]     cur_byte,
   output edge_result_type     result
);

   edge_entry_type mem [DEPTH];
   edge_entry_type rd_ff;
   logic [7:0]     low_case;
   logic           fits;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign low_case = cur_byte | 8'h20;

   always_comb begin
      case (rd_ff.kind)
         KIND_LITERAL: fits = (cur_byte == rd_ff.char_code);
         KIND_LETTER:  fits = (low_case >= 8'h61) && (low_case <= 8'h7A);
         KIND_DIGIT:   fits = (cur_byte >= 8'h30) && (cur_byte <= 8'h39);
         KIND_SPACE:   fits = (cur_byte == 8'h20) || (cur_byte >= 8'd9 && cur_byte <= 8'd13);
         KIND_ANY:     fits = (cur_byte != 8'h00);
         default:      fits = 1'b0;
      endcase
   end

   assign result.hit    = fits;
   assign result.target = rd_ff.target;

endmodule

`default_nettype wire

[hdl/lmt_window_mem.sv]
// ---------------------------------------------------------------------------
// lmt_window_mem
// Circular byte window holding the pending text, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lmt_window_mem import lmt_pkg::*; #(
   parameter int WINDOW = DEF_WINDOW,
   parameter int PW     = $clog2(WINDOW)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [PW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic [PW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [WINDOW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
